FILE: hw/rtl/sogi_phase_rms_estimator_assert.svh
// ----------------------------------------------------------------------------
// SOGI phase RMS estimator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SOGI_PHASE_RMS_ESTIMATOR_ASSERT_SVH
`define SOGI_PHASE_RMS_ESTIMATOR_ASSERT_SVH

// Check cons in the same cycle as ante
`define SPRE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spre assertion failed");

// Check cons in the cycle after ante
`define SPRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spre assertion failed");

`endif

FILE: hw/rtl/spre_pkg.sv
// ----------------------------------------------------------------------------
// SOGI phase RMS estimator package
// Beat types, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package spre_pkg;

  localparam int unsigned Phases = 3;
  localparam int unsigned PhW    = $clog2(Phases);

  localparam logic [31:0] CfgReset     = 32'd3373259;
  localparam logic [15:0] FreqMin      = 16'd20;
  localparam logic [15:0] FreqSub      = 16'd200;
  localparam logic [31:0] InvSqrt2     = 32'd3037000500;
  localparam logic [33:0] GainDivisor  = 34'd100;
  localparam logic [65:0] GainRound    = 66'd50;
  localparam logic [65:0] HalfQ32      = 66'h0_0000_0000_8000_0000;
  localparam logic [65:0] HalfQ48      = 66'h0_0000_8000_0000_0000;

  // Last step index of each serial unit
  localparam logic [5:0] MulLast  = 6'd32;
  localparam logic [5:0] DivLast  = 6'd63;
  localparam logic [5:0] SqrtLast = 6'd31;

  typedef struct packed {
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_b_current;
    logic signed [15:0] phase_c_current;
    logic signed [15:0] output_frequency;
    logic               drive_running;
  } spre_in_t;

  typedef struct packed {
    logic [15:0] phase_a_rms;
    logic [15:0] phase_b_rms;
    logic [15:0] phase_c_rms;
  } spre_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } spre_mul_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GMUL, S_GDIV, S_KDIV, S_ERR, S_YMUL, S_QMUL,
    S_YSQ, S_QSQ, S_SQRT, S_K2S, S_K1A, S_RMS, S_DONE
  } spre_state_e;

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/spre_smul.sv
// ----------------------------------------------------------------------------
// SOGI phase RMS estimator serial multiplier
// Shift-add multiply-accumulate, one multiplier bit per cycle while step is set.
// ----------------------------------------------------------------------------
module spre_smul (
  input  logic                   clk_i,
  input  spre_pkg::spre_mul_ctl_t ctl_i,
  input  logic signed [65:0]     acc_init_i,
  input  logic signed [65:0]     mcand_i,
  input  logic        [32:0]     mplier_i,
  output logic signed [65:0]     acc_next_o
);
  import spre_pkg::*;

  logic signed [65:0] acc_q, acc_d;
  logic signed [65:0] mcand_q, mcand_d;
  logic        [32:0] mplier_q, mplier_d;

  // Add the shifted multiplicand when the current multiplier bit is set
  assign acc_next_o = acc_q + (mplier_q[0] ? mcand_q : 66'sd0);

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (ctl_i.load) begin
      acc_d    = acc_init_i;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
    end else if (ctl_i.step) begin
      acc_d    = acc_next_o;
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

endmodule

FILE: hw/rtl/sogi_phase_rms_estimator.sv
// ----------------------------------------------------------------------------
// SOGI phase RMS estimator
// Per-phase SOGI amplitude tracking with frequency-scaled smoothing.
// ----------------------------------------------------------------------------
// One item is processed at a time: the integrator gain is formed by a product
// and a serial division, the smoothing coefficient by a second division, and
// each phase then runs seven products on the one bit-per-cycle shift-add
// multiplier plus a 32-step square root. A finished result waits in the
// output register while the next beat is accepted.
module sogi_phase_rms_estimator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spre_pkg::spre_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spre_pkg::spre_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_data_i
);
  import spre_pkg::*;

  spre_state_e state_q, state_d;
  logic [5:0]     cnt_q, cnt_d;
  logic [PhW-1:0] phase_q, phase_d;
  logic [31:0]    cfg_q;
  logic           out_valid_q, out_valid_d;
  spre_out_t      out_q, out_d;

  logic signed [15:0] x_q [Phases];
  logic signed [15:0] x_d [Phases];
  logic signed [31:0] y_q [Phases];
  logic signed [31:0] y_d [Phases];
  logic signed [31:0] q_q [Phases];
  logic signed [31:0] q_d [Phases];
  logic        [31:0] s_q [Phases];
  logic        [31:0] s_d [Phases];
  logic        [15:0] rms_q [Phases];
  logic        [15:0] rms_d [Phases];

  logic [31:0] g_q, g_d, k1_q, k1_d, a_q, a_d;
  logic [34:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [33:0] dvsr_q, dvsr_d;
  logic [63:0] v_q, v_d, r_q, r_d, bit_q, bit_d;

  spre_mul_ctl_t      mul_ctl;
  logic signed [65:0] mul_acc_init, mul_mcand, mul_acc_next;
  logic        [32:0] mul_mplier;

  logic               in_fire;
  logic        [15:0] fmag, fsel;
  logic        [34:0] rem_sh, rem_nx;
  logic        [63:0] num_sh, num_nx;
  logic               div_ge;
  logic        [31:0] g_new;
  logic        [29:0] w_new;
  logic        [63:0] sq_t, v_nx, r_nx, bit_nx;
  logic               sq_ge;
  logic signed [15:0] x_c;
  logic signed [31:0] y_c, q_c, es, y_upd, q_upd;
  logic        [31:0] s_c, abs_y, abs_q;
  logic signed [33:0] e_w, mul_hi;
  logic        [32:0] k2;

  spre_smul u_smul (
    .clk_i,
    .ctl_i      (mul_ctl),
    .acc_init_i (mul_acc_init),
    .mcand_i    (mul_mcand),
    .mplier_i   (mul_mplier),
    .acc_next_o (mul_acc_next)
  );

  // Handshakes
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Frequency magnitude with low-speed substitute
  assign fmag = in_data_i.output_frequency[15] ? (~in_data_i.output_frequency + 16'd1)
                                               : in_data_i.output_frequency;
  assign fsel = (fmag < FreqMin) ? FreqSub : fmag;

  // Restoring division step
  assign rem_sh = {rem_q[33:0], num_q[63]};
  assign num_sh = {num_q[62:0], 1'b0};
  assign div_ge = (rem_sh >= {1'b0, dvsr_q});
  assign rem_nx = div_ge ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;
  assign num_nx = {num_sh[63:1], div_ge};
  assign g_new  = (num_nx[63:32] != 32'd0) ? 32'hFFFF_FFFF : num_nx[31:0];
  assign w_new  = g_new[31:2];

  // Square root step
  assign sq_t   = r_q + bit_q;
  assign sq_ge  = (v_q >= sq_t);
  assign v_nx   = sq_ge ? (v_q - sq_t) : v_q;
  assign r_nx   = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
  assign bit_nx = bit_q >> 2;

  // Current phase operands
  assign x_c    = x_q[phase_q];
  assign y_c    = y_q[phase_q];
  assign q_c    = q_q[phase_q];
  assign s_c    = s_q[phase_q];
  assign e_w    = {{2{x_c[15]}}, x_c, 16'd0} - 34'(y_c) - 34'(q_c);
  assign es     = sat32(35'(e_w));
  assign mul_hi = mul_acc_next[65:32];
  assign y_upd  = sat32(35'(y_c) + 35'(mul_hi));
  assign q_upd  = sat32(35'(q_c) + 35'(mul_hi));
  assign abs_y  = y_c[31] ? (~y_c + 32'd1) : y_c;
  assign abs_q  = q_c[31] ? (~q_c + 32'd1) : q_c;
  assign k2     = 33'h1_0000_0000 - {1'b0, k1_q};

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    phase_d      = phase_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    x_d          = x_q;
    y_d          = y_q;
    q_d          = q_q;
    s_d          = s_q;
    rms_d        = rms_q;
    g_d          = g_q;
    k1_d         = k1_q;
    a_d          = a_q;
    rem_d        = rem_q;
    num_d        = num_q;
    dvsr_d       = dvsr_q;
    v_d          = v_q;
    r_d          = r_q;
    bit_d        = bit_q;
    mul_ctl      = '0;
    mul_acc_init = '0;
    mul_mcand    = '0;
    mul_mplier   = '0;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_d[0] = in_data_i.drive_running ? in_data_i.phase_a_current : 16'sd0;
          x_d[1] = in_data_i.drive_running ? in_data_i.phase_b_current : 16'sd0;
          x_d[2] = in_data_i.drive_running ? in_data_i.phase_c_current : 16'sd0;
          if (!in_data_i.drive_running) begin
            for (int p = 0; p < Phases; p++) begin
              y_d[p] = 32'sd0;
              q_d[p] = 32'sd0;
            end
          end
          mul_ctl.load = 1'b1;
          mul_acc_init = GainRound;
          mul_mcand    = {34'd0, cfg_q};
          mul_mplier   = {17'd0, fsel};
          cnt_d        = 6'd0;
          state_d      = S_GMUL;
        end
      end

      S_GMUL: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          num_d   = mul_acc_next[63:0];
          rem_d   = '0;
          dvsr_d  = GainDivisor;
          cnt_d   = 6'd0;
          state_d = S_GDIV;
        end
      end

      S_GDIV: begin
        rem_d = rem_nx;
        num_d = num_nx;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DivLast) begin
          g_d     = g_new;
          num_d   = {2'b00, w_new, 32'd0};
          rem_d   = '0;
          dvsr_d  = {2'b01, 2'b00, w_new};
          cnt_d   = 6'd0;
          state_d = S_KDIV;
        end
      end

      S_KDIV: begin
        rem_d = rem_nx;
        num_d = num_nx;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DivLast) begin
          k1_d    = num_nx[31:0];
          phase_d = '0;
          cnt_d   = 6'd0;
          state_d = S_ERR;
        end
      end

      // Form the clamped integrator error and start its gain product
      S_ERR: begin
        mul_ctl.load = 1'b1;
        mul_acc_init = HalfQ32;
        mul_mcand    = 66'(es);
        mul_mplier   = {1'b0, g_q};
        cnt_d        = 6'd0;
        state_d      = S_YMUL;
      end

      S_YMUL: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          y_d[phase_q] = y_upd;
          mul_ctl.load = 1'b1;
          mul_acc_init = HalfQ32;
          mul_mcand    = 66'(y_upd);
          mul_mplier   = {1'b0, g_q};
          cnt_d        = 6'd0;
          state_d      = S_QMUL;
        end
      end

      S_QMUL: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          q_d[phase_q] = q_upd;
          mul_ctl.load = 1'b1;
          mul_acc_init = '0;
          mul_mcand    = {34'd0, abs_y};
          mul_mplier   = {1'b0, abs_y};
          cnt_d        = 6'd0;
          state_d      = S_YSQ;
        end
      end

      // Accumulate the quadrature square onto the in-phase square
      S_YSQ: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          mul_ctl.load = 1'b1;
          mul_acc_init = mul_acc_next;
          mul_mcand    = {34'd0, abs_q};
          mul_mplier   = {1'b0, abs_q};
          cnt_d        = 6'd0;
          state_d      = S_QSQ;
        end
      end

      S_QSQ: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          v_d     = mul_acc_next[63:0];
          r_d     = '0;
          bit_d   = 64'h4000_0000_0000_0000;
          cnt_d   = 6'd0;
          state_d = S_SQRT;
        end
      end

      S_SQRT: begin
        v_d   = v_nx;
        r_d   = r_nx;
        bit_d = bit_nx;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == SqrtLast) begin
          a_d          = r_nx[31:0];
          mul_ctl.load = 1'b1;
          mul_acc_init = HalfQ32;
          mul_mcand    = {34'd0, s_c};
          mul_mplier   = k2;
          cnt_d        = 6'd0;
          state_d      = S_K2S;
        end
      end

      S_K2S: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          mul_ctl.load = 1'b1;
          mul_acc_init = mul_acc_next;
          mul_mcand    = {34'd0, a_q};
          mul_mplier   = {1'b0, k1_q};
          cnt_d        = 6'd0;
          state_d      = S_K1A;
        end
      end

      S_K1A: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          s_d[phase_q] = mul_acc_next[63:32];
          mul_ctl.load = 1'b1;
          mul_acc_init = HalfQ48;
          mul_mcand    = {34'd0, mul_acc_next[63:32]};
          mul_mplier   = {1'b0, InvSqrt2};
          cnt_d        = 6'd0;
          state_d      = S_RMS;
        end
      end

      // Scale to RMS, then advance to the next phase or finish after the last one
      S_RMS: begin
        mul_ctl.step = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          rms_d[phase_q] = mul_acc_next[63:48];
          cnt_d          = 6'd0;
          if (phase_q == PhW'(Phases - 1)) begin
            state_d = S_DONE;
          end else begin
            phase_d = phase_q + PhW'(1);
            state_d = S_ERR;
          end
        end
      end

      // Hold until the output register is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.phase_a_rms = rms_q[0];
          out_d.phase_b_rms = rms_q[1];
          out_d.phase_c_rms = rms_q[2];
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= CfgReset;
      for (int p = 0; p < Phases; p++) begin
        y_q[p] <= '0;
        q_q[p] <= '0;
        s_q[p] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      y_q <= y_d;
      q_q <= q_d;
      s_q <= s_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    x_q    <= x_d;
    rms_q  <= rms_d;
    g_q    <= g_d;
    k1_q   <= k1_d;
    a_q    <= a_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    dvsr_q <= dvsr_d;
    v_q    <= v_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
  end

`include "sogi_phase_rms_estimator_assert.svh"

  `SPRE_ASSERT_NEXT(a_one_item, in_fire, !in_ready_o)
  `SPRE_ASSERT_NEXT(a_done_out, (state_q == S_DONE) && (!out_valid_q || out_ready_i), out_valid_o && in_ready_o)
  `SPRE_ASSERT_SAME(a_sqrt_cnt, state_q == S_SQRT, cnt_q <= SqrtLast)

endmodule
